>>> design/knapsack_fitness_elite_select_unit_assert.svh
`ifndef KNAPSACK_FITNESS_ELITE_SELECT_UNIT_ASSERT_SVH
`define KNAPSACK_FITNESS_ELITE_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication
`define KFES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define KFES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/kfes_pkg.sv
package kfes_pkg;

    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int BYTE_W     = 8;
    localparam int GENE_BITS  = 40;
    localparam int SCORE_W    = 14;
    localparam int SUM_W      = 14;
    localparam int RANK_W     = 3;
    localparam int MEMBER_W   = 4;
    localparam int RESULT_CAP = 8;

    localparam logic [KIND_W-1:0] KIND_GENE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHROMO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd2;

    localparam logic [SCORE_W-1:0] CAP_RESET = 14'd100;

    typedef struct packed {
        logic load;
        logic eval_start;
        logic chr_rd;
        logic gene_ld;
        logic gene_acc;
        logic score_wr;
        logic scan_ld;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic gene_last;
        logic member_last;
        logic idx_last;
        logic rank_last;
        logic out_free;
    } t_sts;

endpackage

>>> design/kfes_ifs.sv
interface kfes_in_if;
    import kfes_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot;
    logic [BYTE_W-1:0]    gene_weight;
    logic [BYTE_W-1:0]    gene_value;
    logic [GENE_BITS-1:0] genes;
    modport source (output valid, kind, slot, gene_weight, gene_value, genes, input ready);
    modport sink (input valid, kind, slot, gene_weight, gene_value, genes, output ready);
endinterface

interface kfes_out_if;
    import kfes_pkg::*;
    logic                valid;
    logic                ready;
    logic [RANK_W-1:0]   rank;
    logic [MEMBER_W-1:0] member;
    logic [SCORE_W-1:0]  score;
    logic                last;
    modport source (output valid, rank, member, score, last, input ready);
    modport sink (input valid, rank, member, score, last, output ready);
endinterface

interface kfes_cfg_if;
    import kfes_pkg::*;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> design/knapsack_fitness_elite_select_unit.sv
// Load transactions (gene entry or chromosome): one per cycle, no result.
// Evaluate: scoring takes one gene per cycle through the shared accumulator, member by
// member; then each of min(PARENTS,POP,8) results comes from a scan of the score store
// over every member, then waits out any output stall. Input is held off until done.
// Reset clears control state, selection marks and output valid; capacity resets to 100.
// Gene tables and chromosome store are undefined until written.
module knapsack_fitness_elite_select_unit #(
    parameter int GENES   = 40,
    parameter int POP     = 16,
    parameter int PARENTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kfes_in_if.sink           i_in,
    kfes_cfg_if.sink          i_cfg,
    kfes_out_if.source        o_res
);
    import kfes_pkg::*;

`include "knapsack_fitness_elite_select_unit_assert.svh"

    localparam int RES_A = (PARENTS < POP) ? PARENTS : POP;
    localparam int RES_N = (RES_A < RESULT_CAP) ? RES_A : RESULT_CAP;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    kfes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kfes_dp #(
        .GENES   (GENES),
        .POP     (POP),
        .PARENTS (PARENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_in.kind),
        .i_slot        (i_in.slot),
        .i_gene_weight (i_in.gene_weight),
        .i_gene_value  (i_in.gene_value),
        .i_genes       (i_in.genes),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_rank        (o_res.rank),
        .o_member      (o_res.member),
        .o_score       (o_res.score),
        .o_last        (o_res.last)
    );

    `KFES_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.kind == KIND_EVAL), !i_in.ready, "input ready straight after evaluate")
    `KFES_ASSERT_NOW(a_last_rank, i_clk, i_rst_n, o_res.valid && o_res.last, o_res.rank == RANK_W'(RES_N - 1), "last flag on wrong rank")
    `KFES_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, cmd.emit, sts.out_free, "result overwrites pending transaction")

endmodule

>>> design/kfes_ctrl.sv
module kfes_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [kfes_pkg::KIND_W-1:0] i_in_kind,
    output logic                        o_in_ready,
    input  kfes_pkg::t_sts              i_sts,
    output kfes_pkg::t_cmd              o_cmd
);
    import kfes_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CHR_RD   = 8'b0000_0010,
        S_GENE_LD  = 8'b0000_0100,
        S_GENE_ACC = 8'b0000_1000,
        S_SCORE_WR = 8'b0001_0000,
        S_SCAN_LD  = 8'b0010_0000,
        S_SCAN     = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_kind == KIND_EVAL) begin
                        o_cmd.eval_start = 1'b1;
                        n_state          = S_CHR_RD;
                    end
                end
            end
            S_CHR_RD: begin
                o_cmd.chr_rd = 1'b1;
                n_state      = S_GENE_LD;
            end
            S_GENE_LD: begin
                o_cmd.gene_ld = 1'b1;
                n_state       = S_GENE_ACC;
            end
            S_GENE_ACC: begin
                o_cmd.gene_acc = 1'b1;
                if (i_sts.gene_last) begin
                    n_state = S_SCORE_WR;
                end
            end
            S_SCORE_WR: begin
                o_cmd.score_wr = 1'b1;
                n_state        = i_sts.member_last ? S_SCAN_LD : S_CHR_RD;
            end
            S_SCAN_LD: begin
                o_cmd.scan_ld = 1'b1;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.rank_last ? S_IDLE : S_SCAN_LD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/kfes_dp.sv
module kfes_dp #(
    parameter int GENES   = 40,
    parameter int POP     = 16,
    parameter int PARENTS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kfes_pkg::t_cmd                 i_cmd,
    output kfes_pkg::t_sts                 o_sts,
    input  logic [kfes_pkg::KIND_W-1:0]    i_kind,
    input  logic [kfes_pkg::SLOT_W-1:0]    i_slot,
    input  logic [kfes_pkg::BYTE_W-1:0]    i_gene_weight,
    input  logic [kfes_pkg::BYTE_W-1:0]    i_gene_value,
    input  logic [kfes_pkg::GENE_BITS-1:0] i_genes,
    input  logic                           i_cfg_valid,
    input  logic [kfes_pkg::SCORE_W-1:0]   i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [kfes_pkg::RANK_W-1:0]    o_rank,
    output logic [kfes_pkg::MEMBER_W-1:0]  o_member,
    output logic [kfes_pkg::SCORE_W-1:0]   o_score,
    output logic                           o_last
);
    import kfes_pkg::*;

    localparam int GENE_N = (GENES < GENE_BITS) ? GENES : GENE_BITS;
    localparam int TAW    = (GENES > 1) ? $clog2(GENES) : 1;
    localparam int PAW    = $clog2(POP);
    localparam int RES_A  = (PARENTS < POP) ? PARENTS : POP;
    localparam int RES_N  = (RES_A < RESULT_CAP) ? RES_A : RESULT_CAP;

    logic [BYTE_W-1:0]    m_weight [GENES];
    logic [BYTE_W-1:0]    m_value  [GENES];
    logic [GENE_BITS-1:0] m_chromo [POP];
    logic [SCORE_W-1:0]   m_score  [POP];

    logic [SCORE_W-1:0]   r_cap;
    logic [GENE_BITS-1:0] r_chr_q;
    logic [GENE_BITS-1:0] r_shift;
    logic [BYTE_W-1:0]    r_w_q;
    logic [BYTE_W-1:0]    r_v_q;
    logic [SUM_W-1:0]     r_wsum;
    logic [SUM_W-1:0]     r_vsum;
    logic [TAW-1:0]       r_gene;
    logic [PAW-1:0]       r_member;
    logic [PAW-1:0]       r_idx;
    logic [SCORE_W-1:0]   r_sc_q;
    logic [PAW-1:0]       r_best;
    logic [SCORE_W-1:0]   r_best_sc;
    logic                 r_best_vld;
    logic [POP-1:0]       r_taken;
    logic [RANK_W-1:0]    r_rank;
    logic                 r_out_vld;

    logic                 tbl_we;
    logic                 tbl_re;
    logic [TAW-1:0]       tbl_ra;
    logic                 chr_we;
    logic                 sc_re;
    logic [PAW-1:0]       sc_ra;
    logic [SCORE_W-1:0]   score_new;
    logic [7:0]           best_ext;
    logic                 better;

    always_comb begin
        o_sts.gene_last   = (r_gene == TAW'(GENE_N - 1));
        o_sts.member_last = (r_member == PAW'(POP - 1));
        o_sts.idx_last    = (r_idx == PAW'(POP - 1));
        o_sts.rank_last   = (r_rank == RANK_W'(RES_N - 1));
        o_sts.out_free    = !r_out_vld || i_out_ready;
    end

    assign tbl_we = i_cmd.load && (i_kind == KIND_GENE) && (7'(i_slot) < 7'(GENES));
    assign chr_we = i_cmd.load && (i_kind == KIND_CHROMO) && (7'(i_slot) < 7'(POP));
    assign tbl_re = i_cmd.gene_ld || (i_cmd.gene_acc && !o_sts.gene_last);
    assign tbl_ra = i_cmd.gene_ld ? '0 : r_gene + TAW'(1);
    assign sc_re  = i_cmd.scan_ld || (i_cmd.scan_step && !o_sts.idx_last);
    assign sc_ra  = i_cmd.scan_ld ? '0 : r_idx + PAW'(1);

    // sums of at most 40 bytes stay below the score ceiling
    assign score_new = (r_wsum > r_cap) ? '0 : r_vsum;
    assign better    = !r_taken[r_idx] && (!r_best_vld || (r_sc_q > r_best_sc));
    assign best_ext  = 8'(r_best);

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            m_weight[i_slot[TAW-1:0]] <= i_gene_weight;
            m_value[i_slot[TAW-1:0]]  <= i_gene_value;
        end
        if (tbl_re) begin
            r_w_q <= m_weight[tbl_ra];
            r_v_q <= m_value[tbl_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (chr_we) begin
            m_chromo[i_slot[PAW-1:0]] <= i_genes;
        end
        if (i_cmd.chr_rd) begin
            r_chr_q <= m_chromo[r_member];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.score_wr) begin
            m_score[r_member] <= score_new;
        end
        if (sc_re) begin
            r_sc_q <= m_score[sc_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gene_ld) begin
            r_shift <= r_chr_q;
            r_wsum  <= '0;
            r_vsum  <= '0;
            r_gene  <= '0;
        end else if (i_cmd.gene_acc) begin
            if (r_shift[0]) begin
                r_wsum <= r_wsum + SUM_W'(r_w_q);
                r_vsum <= r_vsum + SUM_W'(r_v_q);
            end
            r_shift <= r_shift >> 1;
            r_gene  <= r_gene + TAW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_start) begin
            r_member <= '0;
        end else if (i_cmd.score_wr && !o_sts.member_last) begin
            r_member <= r_member + PAW'(1);
        end
        if (i_cmd.scan_ld) begin
            r_idx      <= '0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (better) begin
                r_best     <= r_idx;
                r_best_sc  <= r_sc_q;
                r_best_vld <= 1'b1;
            end
            r_idx <= r_idx + PAW'(1);
        end
        if (i_cmd.eval_start) begin
            r_rank <= '0;
        end else if (i_cmd.emit) begin
            r_rank <= r_rank + RANK_W'(1);
        end
        if (i_cmd.emit) begin
            o_rank   <= r_rank;
            o_member <= best_ext[MEMBER_W-1:0];
            o_score  <= r_best_sc;
            o_last   <= o_sts.rank_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_taken   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.eval_start) begin
                r_taken <= '0;
            end else if (i_cmd.emit) begin
                r_taken[r_best] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

>>> bench/knapsack_fitness_elite_select_unit_tb.sv
module knapsack_fitness_elite_select_unit_tb;
    import kfes_pkg::*;

    localparam int NUM_GENES     = 40;
    localparam int POP_SIZE      = 16;
    localparam int ELITE         = 8;
    localparam int PICKS_POP     = (ELITE < POP_SIZE) ? ELITE : POP_SIZE;
    localparam int PICKS         = (PICKS_POP < RESULT_CAP) ? PICKS_POP : RESULT_CAP;
    localparam int PHASE_ITEMS   = 18;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int MAX_PRINTS    = 50;
    localparam int DIR_ROWS      = 23;

    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;
    localparam logic [SCORE_W-1:0] CAP_MAX     = '1;

    typedef enum logic {ACT_ITEM, ACT_CAP} t_row_act;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [SLOT_W-1:0]    slot;
        logic [BYTE_W-1:0]    weight;
        logic [BYTE_W-1:0]    value;
        logic [GENE_BITS-1:0] genes;
    } t_kfes_item;

    typedef struct {
        logic [RANK_W-1:0]   rank;
        logic [MEMBER_W-1:0] member;
        logic [SCORE_W-1:0]  score;
        logic                last;
    } t_elite_pick;

    typedef struct {
        t_row_act             act;
        logic [KIND_W-1:0]    kind;
        logic [SLOT_W-1:0]    slot;
        logic [BYTE_W-1:0]    weight;
        logic [BYTE_W-1:0]    value;
        logic [GENE_BITS-1:0] genes;
        logic [SCORE_W-1:0]   cap;
        bit                   pinned;
        logic [MEMBER_W-1:0]  top_member;
        logic [SCORE_W-1:0]   top_score;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kfes_in_if  in_ch();
    kfes_cfg_if cfg_ch();
    kfes_out_if res_ch();

    knapsack_fitness_elite_select_unit #(
        .GENES   (NUM_GENES),
        .POP     (POP_SIZE),
        .PARENTS (ELITE)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [BYTE_W-1:0]    gene_wt   [NUM_GENES];
    logic [BYTE_W-1:0]    gene_val  [NUM_GENES];
    logic [GENE_BITS-1:0] pop_genes [POP_SIZE];
    logic [SCORE_W-1:0]   capacity_q = CAP_RESET;
    t_elite_pick          elite_q [$];

    int fail_cnt     = 0;
    int snd_idle_pct = 18;
    int rcv_idle_pct = 85;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    t_dir_row directed_rows [DIR_ROWS];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_cnt < MAX_PRINTS) begin
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        end
        fail_cnt++;
    endtask

    task automatic knapsack_predict(input t_kfes_item it, input bit pinned,
                                    input logic [MEMBER_W-1:0] top_member,
                                    input logic [SCORE_W-1:0] top_score);
        logic [SCORE_W-1:0]  fitness [POP_SIZE];
        logic [POP_SIZE-1:0] taken;
        t_elite_pick         pick;
        int unsigned         wsum;
        int unsigned         vsum;
        int                  best;
        case (it.kind)
            KIND_GENE: begin
                if (it.slot < NUM_GENES) begin
                    gene_wt[it.slot]  = it.weight;
                    gene_val[it.slot] = it.value;
                end
            end
            KIND_CHROMO: begin
                if (it.slot < POP_SIZE) begin
                    pop_genes[it.slot] = it.genes;
                end
            end
            KIND_EVAL: begin
                for (int i = 0; i < POP_SIZE; i++) begin
                    wsum = 0;
                    vsum = 0;
                    for (int j = 0; j < NUM_GENES && j < GENE_BITS; j++) begin
                        if (pop_genes[i][j]) begin
                            wsum += gene_wt[j];
                            vsum += gene_val[j];
                        end
                    end
                    if (wsum > capacity_q) begin
                        fitness[i] = '0;
                    end else if (vsum > SCORE_MAX) begin
                        fitness[i] = SCORE_MAX;
                    end else begin
                        fitness[i] = vsum[SCORE_W-1:0];
                    end
                end
                taken = '0;
                for (int r = 0; r < PICKS; r++) begin
                    best = -1;
                    for (int i = 0; i < POP_SIZE; i++) begin
                        if (!taken[i] && (best < 0 || fitness[i] > fitness[best])) begin
                            best = i;
                        end
                    end
                    taken[best] = 1'b1;
                    pick.rank   = r[RANK_W-1:0];
                    pick.member = best[MEMBER_W-1:0];
                    pick.score  = fitness[best];
                    pick.last   = (r == PICKS - 1);
                    if (pinned && r == 0) begin
                        pick.member = top_member;
                        pick.score  = top_score;
                    end
                    elite_q.insert(elite_q.size(), pick);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input t_kfes_item it, input bit pinned,
                             input logic [MEMBER_W-1:0] top_member,
                             input logic [SCORE_W-1:0] top_score);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= it.kind;
        in_ch.slot        <= it.slot;
        in_ch.gene_weight <= it.weight;
        in_ch.gene_value  <= it.value;
        in_ch.genes       <= it.genes;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        knapsack_predict(it, pinned, top_member, top_score);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (elite_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [SCORE_W-1:0] new_cap);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= new_cap;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        capacity_q = new_cap;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_elite_pick want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (elite_q.size() == 0) begin
                report_mismatch("unexpected transaction, member", res_ch.member, -1);
            end else begin
                want = elite_q.pop_front();
                if (res_ch.rank !== want.rank) begin
                    report_mismatch("rank", res_ch.rank, want.rank);
                end
                if (res_ch.member !== want.member) begin
                    report_mismatch("member", res_ch.member, want.member);
                end
                if (res_ch.score !== want.score) begin
                    report_mismatch("score", res_ch.score, want.score);
                end
                if (res_ch.last !== want.last) begin
                    report_mismatch("last", res_ch.last, want.last);
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_kfes_item         it;
        t_dir_row           row;
        int                 pick;
        logic [63:0]        r64;
        logic [SCORE_W-1:0] phase_cap;

        directed_rows = '{
            // act     kind         slot   wt      val     genes             cap
            //                                                      pin   member top score
            '{ACT_ITEM, KIND_EVAL,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b1, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_GENE,   6'd39, 8'd255, 8'd255, 40'h0,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_GENE,   6'd63, 8'hAA,  8'h55,  40'h0,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_CHROMO, 6'd15, 8'd0,   8'd0,   40'h80_0000_0000, 14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_CHROMO, 6'd63, 8'd0,   8'd0,   40'hFF_FFFF_FFFF, 14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_UNUSED, 6'd15, 8'd255, 8'd255, 40'hFF_FFFF_FFFF, 14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_EVAL,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b1, 4'd0,  14'd0},
            '{ACT_CAP,  KIND_GENE,   6'd0,  8'd0,   8'd0,   40'h0,            CAP_MAX,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_EVAL,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b1, 4'd15, 14'd255},
            '{ACT_ITEM, KIND_GENE,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_GENE,   6'd1,  8'd0,   8'd255, 40'h0,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_CHROMO, 6'd0,  8'd0,   8'd0,   40'hFF_FFFF_FFFF, 14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_EVAL,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_GENE,   6'd2,  8'd0,   8'd200, 40'h0,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_CHROMO, 6'd3,  8'd0,   8'd0,   40'h4,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_CHROMO, 6'd9,  8'd0,   8'd0,   40'h4,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_CHROMO, 6'd5,  8'd0,   8'd0,   40'h4,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_CAP,  KIND_GENE,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_EVAL,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b1, 4'd3,  14'd200},
            '{ACT_CAP,  KIND_GENE,   6'd0,  8'd0,   8'd0,   40'h0,            14'd255,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_EVAL,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b1, 4'd15, 14'd255},
            '{ACT_CAP,  KIND_GENE,   6'd0,  8'd0,   8'd0,   40'h0,            CAP_RESET,
              1'b0, 4'd0,  14'd0},
            '{ACT_ITEM, KIND_EVAL,   6'd0,  8'd0,   8'd0,   40'h0,            14'd0,
              1'b0, 4'd0,  14'd0}
        };

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_GENE;
        in_ch.slot        = '0;
        in_ch.gene_weight = '0;
        in_ch.gene_value  = '0;
        in_ch.genes       = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        res_ch.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // initialise every gene entry and every member before the first evaluate
        for (int g = 0; g < NUM_GENES; g++) begin
            it.kind   = KIND_GENE;
            it.slot   = g[SLOT_W-1:0];
            it.weight = 8'd1;
            it.value  = 8'd1;
            it.genes  = '0;
            send_item(it, 1'b0, '0, '0);
        end
        for (int m = 0; m < POP_SIZE; m++) begin
            it.kind   = KIND_CHROMO;
            it.slot   = m[SLOT_W-1:0];
            it.weight = '0;
            it.value  = '0;
            it.genes  = '0;
            send_item(it, 1'b0, '0, '0);
        end

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.act == ACT_CAP) begin
                wait_idle();
                write_capacity(row.cap);
            end else begin
                it.kind   = row.kind;
                it.slot   = row.slot;
                it.weight = row.weight;
                it.value  = row.value;
                it.genes  = row.genes;
                send_item(it, row.pinned, row.top_member, row.top_score);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    snd_idle_pct = 18;
                    rcv_idle_pct = 85;
                    phase_cap    = SCORE_W'($urandom_range(60, 200));
                end
                1: begin
                    snd_idle_pct = 85;
                    rcv_idle_pct = 18;
                    phase_cap    = CAP_MAX;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    phase_cap    = SCORE_W'($urandom_range(100, 600));
                end
            endcase
            write_capacity(phase_cap);
            if (ph == 2) begin
                hold_reqs++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (ph == 2 && (n == 2 || n == 3)) begin
                    it.kind = KIND_EVAL;
                end else if (pick < 38) begin
                    it.kind = KIND_GENE;
                end else if (pick < 76) begin
                    it.kind = KIND_CHROMO;
                end else if (pick < 89) begin
                    it.kind = KIND_EVAL;
                end else begin
                    it.kind = KIND_UNUSED;
                end
                if (it.kind == KIND_GENE && $urandom_range(0, 9) != 0) begin
                    it.slot = SLOT_W'($urandom_range(0, NUM_GENES - 1));
                end else if (it.kind == KIND_CHROMO && $urandom_range(0, 9) != 0) begin
                    it.slot = SLOT_W'($urandom_range(0, POP_SIZE - 1));
                end else begin
                    it.slot = SLOT_W'($urandom_range(0, 63));
                end
                it.weight = BYTE_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 255));
                it.value  = BYTE_W'($urandom_range(0, 255));
                r64 = {$urandom, $urandom};
                case ($urandom_range(0, 5))
                    0: it.genes = r64[GENE_BITS-1:0];
                    1, 2: begin
                        r64 = r64 & {$urandom, $urandom} & {$urandom, $urandom};
                        it.genes = r64[GENE_BITS-1:0];
                    end
                    3: it.genes = '1;
                    4: it.genes = '0;
                    default: begin
                        it.genes = '0;
                        it.genes[$urandom_range(0, GENE_BITS - 1)] = 1'b1;
                    end
                endcase
                send_item(it, 1'b0, '0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
